>>> hdl/homogeneous_point_transform_2d_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_2D_TOP_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_2D_TOP_DEFINES_SVH

// same-cycle implication
`define HPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hpt2d_pkg.sv
// ----------------------------------------------------------------------------
// hpt2d_pkg
// Shared constants and register codes of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt2d_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int PORT_W         = 32;
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_XX    = 3'd0,
		REG_COEF_XY    = 3'd1,
		REG_COEF_YX    = 3'd2,
		REG_COEF_YY    = 3'd3,
		REG_OFFSET_X   = 3'd4,
		REG_OFFSET_Y   = 3'd5,
		REG_PERSP_PAIR = 3'd6,
		REG_PERSP_BIAS = 3'd7
	} cfg_reg_t;

endpackage

>>> hdl/hpt2d_div.sv
// ----------------------------------------------------------------------------
// hpt2d_div
// Two-lane pipelined restoring divider, shared divisor, one quotient bit per
// stage. Remainder must enter already reduced below the divisor; not checked.
// ----------------------------------------------------------------------------
module hpt2d_div #(
	parameter int K  = 32,
	parameter int MW = 65
) (
	input  logic                clk,
	input  logic                en,
	input  logic [1:0][MW-1:0]  rem_in,
	input  logic [1:0][K-1:0]   lo_in,
	input  logic [MW-1:0]       den_in,
	output logic [1:0][K-1:0]   quo
);
	logic [1:0][MW-1:0] rem_s [0:K];
	logic [1:0][K-1:0]  lo_s  [0:K];
	logic [1:0][K-1:0]  q_s   [0:K];
	logic [MW-1:0]      den_s [0:K];

	assign rem_s[0] = rem_in;
	assign lo_s[0]  = lo_in;
	assign q_s[0]   = '0;
	assign den_s[0] = den_in;

	for (genvar s = 0; s < K; s++) begin : g_step
		logic [1:0][MW:0] r2;
		logic [1:0]       ge;

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l] = {rem_s[s][l], lo_s[s][l][K-1]};
				ge[l] = r2[l] >= {1'b0, den_s[s]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[s+1][l] <= ge[l] ? MW'(r2[l] - {1'b0, den_s[s]}) : MW'(r2[l]);
					lo_s[s+1][l]  <= {lo_s[s][l][K-2:0], 1'b0};
					q_s[s+1][l]   <= {q_s[s][l][K-2:0], ge[l]};
				end
				den_s[s+1] <= den_s[s];
			end
		end
	end

	assign quo = q_s[K];

endmodule

>>> hdl/homogeneous_point_transform_2d_top.sv
// ----------------------------------------------------------------------------
// Homogeneous 2D point transform
// Row-vector 3x3 homogeneous transform of a Q point with perspective divide,
// truncating toward zero and saturating; zero w flags div_error.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_stall    | point_x, point_y
//  out     | out_valid / out_stall  | out_x, out_y, div_error
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One beat per cycle while out_stall does not hold a valid output beat; the
//  one-bit-per-stage divider follows four arithmetic stages.
//  Reset clears valid bits and loads the identity matrix.
//  A stalled output beat freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`include "homogeneous_point_transform_2d_top_defines.svh"

module homogeneous_point_transform_2d_top #(
	parameter int FRAC_BITS  = hpt2d_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = hpt2d_pkg::WORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hpt2d_pkg::PORT_W-1:0]       point_x,
	input  logic [hpt2d_pkg::PORT_W-1:0]       point_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hpt2d_pkg::PORT_W-1:0]       out_x,
	output logic [hpt2d_pkg::PORT_W-1:0]       out_y,
	output logic                               div_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hpt2d_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hpt2d_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hpt2d_pkg::*;

	localparam int WW  = WORD_WIDTH;
	localparam int K   = WORD_WIDTH;
	localparam int SW  = ((2*WW > WW+FRAC_BITS) ? 2*WW : WW+FRAC_BITS) + 2;
	localparam int MW  = SW - 1;
	localparam int NW  = MW + FRAC_BITS;
	localparam logic [PORT_W-1:0] ONE_Q   = PORT_W'(64'd1 << FRAC_BITS);
	localparam logic [K-1:0]      HALF    = K'(64'd1 << (K-1));
	localparam logic [PORT_W-1:0] SAT_POS = PORT_W'((64'd1 << (WW-1)) - 64'd1);

	typedef struct packed {
		logic err;
		logic negx;
		logic negy;
		logic ovx;
		logic ovy;
	} meta_t;

	// configuration
	logic [PORT_W-1:0]     coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	logic [PORT_W-1:0]     offset_x_q, offset_y_q, persp_bias_q;
	logic [CFG_DATA_W-1:0] persp_pair_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q    <= ONE_Q;
			coef_xy_q    <= '0;
			coef_yx_q    <= '0;
			coef_yy_q    <= ONE_Q;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			persp_pair_q <= '0;
			persp_bias_q <= ONE_Q;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_XX:    coef_xx_q    <= cfg_data[PORT_W-1:0];
				REG_COEF_XY:    coef_xy_q    <= cfg_data[PORT_W-1:0];
				REG_COEF_YX:    coef_yx_q    <= cfg_data[PORT_W-1:0];
				REG_COEF_YY:    coef_yy_q    <= cfg_data[PORT_W-1:0];
				REG_OFFSET_X:   offset_x_q   <= cfg_data[PORT_W-1:0];
				REG_OFFSET_Y:   offset_y_q   <= cfg_data[PORT_W-1:0];
				REG_PERSP_PAIR: persp_pair_q <= cfg_data;
				REG_PERSP_BIAS: persp_bias_q <= cfg_data[PORT_W-1:0];
			endcase
		end
	end

	logic signed [WW-1:0] c_xx, c_xy, c_yx, c_yy, c_wx, c_wy, o_x, o_y, o_w, px, py;
	assign c_xx = coef_xx_q[WW-1:0];
	assign c_xy = coef_xy_q[WW-1:0];
	assign c_yx = coef_yx_q[WW-1:0];
	assign c_yy = coef_yy_q[WW-1:0];
	assign c_wx = persp_pair_q[WW-1:0];
	assign c_wy = persp_pair_q[PORT_W+WW-1:PORT_W];
	assign o_x  = offset_x_q[WW-1:0];
	assign o_y  = offset_y_q[WW-1:0];
	assign o_w  = persp_bias_q[WW-1:0];
	assign px   = point_x[WW-1:0];
	assign py   = point_y[WW-1:0];

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// valid chain
	logic         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [K:1]   vld_sd;
	logic         vld_last;
	assign vld_last = vld_sd[K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_sd <= '0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_sd <= {vld_sd[K-1:1], vld_s4};
			vld_s5 <= vld_last;
		end
	end

	assign out_valid = vld_s5;

	// s1: products
	logic signed [2*WW-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_wx_s1, p_wy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1 <= px * c_xx;
			p_xy_s1 <= px * c_xy;
			p_yx_s1 <= py * c_yx;
			p_yy_s1 <= py * c_yy;
			p_wx_s1 <= px * c_wx;
			p_wy_s1 <= py * c_wy;
		end
	end

	// s2: sums
	logic signed [SW-1:0] nx_s2, ny_s2, w_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= SW'(p_xx_s1) + SW'(p_yx_s1) + (SW'(o_x) <<< FRAC_BITS);
			ny_s2 <= SW'(p_xy_s1) + SW'(p_yy_s1) + (SW'(o_y) <<< FRAC_BITS);
			w_s2  <= SW'(p_wx_s1) + SW'(p_wy_s1) + (SW'(o_w) <<< FRAC_BITS);
		end
	end

	// s3: sign and magnitude
	logic [MW-1:0] mx_s3, my_s3, mw_s3;
	logic          nx_neg_s3, ny_neg_s3, w_neg_s3, err_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3     <= MW'(nx_s2[SW-1] ? -nx_s2 : nx_s2);
			my_s3     <= MW'(ny_s2[SW-1] ? -ny_s2 : ny_s2);
			mw_s3     <= MW'(w_s2[SW-1] ? -w_s2 : w_s2);
			nx_neg_s3 <= nx_s2[SW-1];
			ny_neg_s3 <= ny_s2[SW-1];
			w_neg_s3  <= w_s2[SW-1];
			err_s3    <= (w_s2 == '0);
		end
	end

	// s4: overflow test and divider seed
	logic [NW-1:0] numx, numy;
	assign numx = {mx_s3, FRAC_BITS'(0)};
	assign numy = {my_s3, FRAC_BITS'(0)};

	logic [1:0][MW-1:0] rem_s4;
	logic [1:0][K-1:0]  lo_s4;
	logic [MW-1:0]      den_s4;
	meta_t              meta_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4[0]    <= MW'(numx[NW-1:K]);
			rem_s4[1]    <= MW'(numy[NW-1:K]);
			lo_s4[0]     <= numx[K-1:0];
			lo_s4[1]     <= numy[K-1:0];
			den_s4       <= mw_s3;
			meta_s4.err  <= err_s3;
			meta_s4.negx <= nx_neg_s3 ^ w_neg_s3;
			meta_s4.negy <= ny_neg_s3 ^ w_neg_s3;
			meta_s4.ovx  <= NW'(numx[NW-1:K]) >= NW'(mw_s3);
			meta_s4.ovy  <= NW'(numy[NW-1:K]) >= NW'(mw_s3);
		end
	end

	// divider stages
	logic [1:0][K-1:0] quo;

	hpt2d_div #(
		.K  (K),
		.MW (MW)
	) u_div (
		.clk    (clk),
		.en     (en),
		.rem_in (rem_s4),
		.lo_in  (lo_s4),
		.den_in (den_s4),
		.quo    (quo)
	);

	meta_t meta_sd [0:K];
	assign meta_sd[0] = meta_s4;

	for (genvar s = 0; s < K; s++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en) begin
				meta_sd[s+1] <= meta_sd[s];
			end
		end
	end

	// s5: sign and saturate
	logic signed [WW-1:0] res_x, res_y;

	always_comb begin
		if (meta_sd[K].negx) begin
			res_x = (meta_sd[K].ovx || quo[0] > HALF) ? signed'(HALF) : signed'(-quo[0]);
		end else begin
			res_x = (meta_sd[K].ovx || quo[0][K-1]) ? signed'(HALF - 1'b1) : signed'(quo[0]);
		end
		if (meta_sd[K].negy) begin
			res_y = (meta_sd[K].ovy || quo[1] > HALF) ? signed'(HALF) : signed'(-quo[1]);
		end else begin
			res_y = (meta_sd[K].ovy || quo[1][K-1]) ? signed'(HALF - 1'b1) : signed'(quo[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x     <= meta_sd[K].err ? '0 : PORT_W'(res_x);
			out_y     <= meta_sd[K].err ? '0 : PORT_W'(res_y);
			div_error <= meta_sd[K].err;
		end
	end

	`HPT_ASSERT_NOW(a_err_zero, out_valid && div_error, out_x == '0 && out_y == '0, "zero w result not cleared")
	`HPT_ASSERT_NEXT(a_in_to_s1, in_valid && !in_stall, vld_s1, "accepted beat lost at first stage")
	`HPT_ASSERT_NEXT(a_sat_pos, en && vld_last && !meta_sd[K].err && meta_sd[K].ovx && !meta_sd[K].negx, out_x == SAT_POS, "positive overflow not saturated")

endmodule
